>>> design/urtc_pkg.sv
// shared types and constants for the ultrasonic ranger with tone control
`default_nettype none

package urtc_pkg;

   localparam int TRIG_W     = 16;
   localparam int SCALE_W    = 16;
   localparam int THRESH_W   = 9;
   localparam int NUM_W      = 32;
   localparam int DIST_W     = 10;
   localparam int DEN_W      = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIST_W-1:0] DIST_MAX   = 10'd1023;
   localparam logic [DIST_W-1:0] DIST_LIMIT = 10'd500;
   localparam logic [DEN_W:0]    SOUND_BASE = 14'd5000;
   localparam logic [3:0]        SOUND_STEP = 4'd10;

   localparam logic [TRIG_W-1:0]   TRIGGER_TICKS_RESET  = 16'd124;
   localparam logic [SCALE_W-1:0]  CM_SCALE_RESET       = 16'd45;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET      = 9'd100;
   localparam logic [NUM_W-1:0]    TONE_NUMERATOR_RESET = 32'd781250;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRIGGER_TICKS  = 2'd0,
      CSR_CM_SCALE       = 2'd1,
      CSR_THRESHOLD      = 2'd2,
      CSR_TONE_NUMERATOR = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SCALE_W-1:0]  scale;
      logic [THRESH_W-1:0] threshold;
      logic [NUM_W-1:0]    numerator;
   } calc_cfg_type;

   typedef struct packed {
      logic              busy;
      logic              tone_on;
      logic [DIST_W-1:0] distance;
      logic [NUM_W-1:0]  divisor;
   } calc_status_type;

endpackage

`default_nettype wire

>>> design/urtc_channels.sv
// tick and result channel interfaces
`default_nettype none

interface urtc_req_if;
   logic valid;
   logic ready;
   logic start_request;
   logic echo_in;

   modport source (output valid, output start_request, output echo_in, input ready);
   modport sink (input valid, input start_request, input echo_in, output ready);
endinterface

interface urtc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         trigger_out;
   logic                         busy_res;
   logic                         measure_done;
   logic [urtc_pkg::DIST_W-1:0]  distance_cm;
   logic                         tone_on;
   logic [urtc_pkg::NUM_W-1:0]   tone_divisor;

   modport source (output valid, output trigger_out, output busy_res, output measure_done,
                   output distance_cm, output tone_on, output tone_divisor, input ready);
   modport sink (input valid, input trigger_out, input busy_res, input measure_done,
                 input distance_cm, input tone_on, input tone_divisor, output ready);
endinterface

`default_nettype wire

>>> design/urtc_range_calc.sv
// bit-serial distance multiply and tone divisor divide
`default_nettype none

module urtc_range_calc #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [COUNT_WIDTH-1:0]   width,
   input  wire urtc_pkg::calc_cfg_type   cfg,
   output      urtc_pkg::calc_status_type status
);

   localparam int PROD_W = COUNT_WIDTH + urtc_pkg::SCALE_W;
   localparam int STEP_W = $clog2(urtc_pkg::NUM_W);
   localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(urtc_pkg::SCALE_W - 1);
   localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(urtc_pkg::NUM_W - 1);

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_MUL,
      CS_CHECK,
      CS_DIV,
      CS_FIN
   } calc_state_type;

   calc_state_type                 state_ff;
   logic [STEP_W-1:0]              step_ff;
   logic [COUNT_WIDTH-1:0]         width_ff;
   logic [PROD_W-1:0]              prod_ff;
   logic [urtc_pkg::DEN_W-1:0]     den_ff;
   logic [urtc_pkg::DEN_W-1:0]     rem_ff;
   logic [urtc_pkg::NUM_W-1:0]     quot_ff;
   logic [urtc_pkg::DIST_W-1:0]    distance_ff;
   logic                           tone_ff;
   logic [urtc_pkg::NUM_W-1:0]     divisor_ff;

   logic [COUNT_WIDTH:0]           mul_sum;
   logic [COUNT_WIDTH-1:0]         cm_raw;
   logic [urtc_pkg::DIST_W-1:0]    cm_sat;
   logic                           dist_ok;
   logic [urtc_pkg::DEN_W:0]       dist_x10;
   logic [urtc_pkg::DEN_W-1:0]     den_calc;
   logic [urtc_pkg::DEN_W:0]       rem_shift;
   logic                           rem_ge;
   logic [urtc_pkg::DEN_W:0]       rem_diff;

   // shift-right add multiplier, one scale bit per cycle
   assign mul_sum = {1'b0, prod_ff[PROD_W-1:urtc_pkg::SCALE_W]}
                  + (prod_ff[0] ? {1'b0, width_ff} : '0);

   // product >> 16, saturated
   assign cm_raw  = prod_ff[PROD_W-1:urtc_pkg::SCALE_W];
   assign cm_sat  = (cm_raw > COUNT_WIDTH'(urtc_pkg::DIST_MAX)) ? urtc_pkg::DIST_MAX
                                                              : cm_raw[urtc_pkg::DIST_W-1:0];
   assign dist_ok = (cm_sat <= {1'b0, cfg.threshold}) && (cm_sat < urtc_pkg::DIST_LIMIT);
   assign dist_x10 = (urtc_pkg::DEN_W+1)'(cm_sat) * (urtc_pkg::DEN_W+1)'(urtc_pkg::SOUND_STEP);
   assign den_calc = urtc_pkg::DEN_W'(urtc_pkg::SOUND_BASE - dist_x10);

   // restoring divide, one quotient bit per cycle
   assign rem_shift = {rem_ff, quot_ff[urtc_pkg::NUM_W-1]};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   assign rem_diff  = rem_shift - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CS_IDLE;
         step_ff     <= '0;
         distance_ff <= '0;
         tone_ff     <= 1'b0;
         divisor_ff  <= '0;
      end else begin
         case (state_ff)
            CS_IDLE: begin
               if (start) begin
                  width_ff <= width;
                  prod_ff  <= {{COUNT_WIDTH{1'b0}}, cfg.scale};
                  step_ff  <= '0;
                  state_ff <= CS_MUL;
               end
            end
            CS_MUL: begin
               prod_ff <= {mul_sum, prod_ff[urtc_pkg::SCALE_W-1:1]};
               step_ff <= step_ff + 1'b1;
               if (step_ff == MUL_LAST) begin
                  state_ff <= CS_CHECK;
               end
            end
            CS_CHECK: begin
               distance_ff <= cm_sat;
               if (dist_ok) begin
                  den_ff   <= den_calc;
                  rem_ff   <= '0;
                  quot_ff  <= cfg.numerator;
                  step_ff  <= '0;
                  state_ff <= CS_DIV;
               end else begin
                  tone_ff  <= 1'b0;
                  state_ff <= CS_IDLE;
               end
            end
            CS_DIV: begin
               rem_ff  <= rem_ge ? rem_diff[urtc_pkg::DEN_W-1:0]
                                 : rem_shift[urtc_pkg::DEN_W-1:0];
               quot_ff <= {quot_ff[urtc_pkg::NUM_W-2:0], rem_ge};
               step_ff <= step_ff + 1'b1;
               if (step_ff == DIV_LAST) begin
                  state_ff <= CS_FIN;
               end
            end
            CS_FIN: begin
               // a zero quotient stays zero instead of wrapping
               divisor_ff <= (quot_ff == '0) ? '0 : quot_ff - 1'b1;
               tone_ff    <= 1'b1;
               state_ff   <= CS_IDLE;
            end
            default: begin
               state_ff <= CS_IDLE;
            end
         endcase
      end
   end

   assign status.busy     = (state_ff != CS_IDLE);
   assign status.tone_on  = tone_ff;
   assign status.distance = distance_ff;
   assign status.divisor  = divisor_ff;

endmodule

`default_nettype wire

>>> design/ultrasonic_ranger_tone_control.sv
// ultrasonic ranger top level: trigger, echo width count and tone control
// result: a tick's beat is registered in the cycle after acceptance; the echo-ending
// tick's beat waits for urtc_range_calc (16 multiply steps, 32 divide steps in tone
// range) and a free result slot; one tick per cycle while the slot is free, but the
// echo-ending tick holds the input until its beat; reset: synchronous, clears phase,
// counts and the result valid, loads register defaults
`default_nettype none

module ultrasonic_ranger_tone_control #(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   urtc_req_if.sink                                req_bus,
   urtc_rsp_if.source                              rsp_bus,
   input  wire logic                               csr_we,
   input  wire logic [urtc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [urtc_pkg::CSR_DATA_W-1:0]    csr_data
);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_TRIG,
      PH_WAIT,
      PH_MEAS
   } phase_type;

   phase_type                        phase_ff;
   logic [COUNT_WIDTH-1:0]           tick_ff;
   logic                             echo_prev_ff;
   logic                             calc_ff;

   logic [urtc_pkg::TRIG_W-1:0]      trigger_ticks_ff;
   logic [urtc_pkg::SCALE_W-1:0]     cm_scale_ff;
   logic [urtc_pkg::THRESH_W-1:0]    threshold_ff;
   logic [urtc_pkg::NUM_W-1:0]       numerator_ff;

   logic                             rsp_valid_ff;
   logic                             rsp_trigger_ff;
   logic                             rsp_busy_ff;
   logic                             rsp_done_ff;
   logic [urtc_pkg::DIST_W-1:0]      rsp_distance_ff;
   logic                             rsp_tone_ff;
   logic [urtc_pkg::NUM_W-1:0]       rsp_divisor_ff;

   logic                             slot_free;
   logic                             req_fire;
   logic                             finish;
   logic                             calc_done;
   logic [urtc_pkg::TRIG_W-1:0]      trig_len;
   logic [COUNT_WIDTH-1:0]           tick_inc;
   urtc_pkg::calc_cfg_type           calc_cfg;
   urtc_pkg::calc_status_type        calc_status;

   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !calc_ff && slot_free;
   assign req_fire  = req_bus.valid && req_bus.ready;
   assign finish    = req_fire && (phase_ff == PH_MEAS) && !req_bus.echo_in;
   assign calc_done = calc_ff && !calc_status.busy && slot_free;
   assign trig_len  = (trigger_ticks_ff == '0) ? urtc_pkg::TRIG_W'(1) : trigger_ticks_ff;
   assign tick_inc  = tick_ff + 1'b1;

   assign calc_cfg.scale     = cm_scale_ff;
   assign calc_cfg.threshold = threshold_ff;
   assign calc_cfg.numerator = numerator_ff;

   urtc_range_calc #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_calc (
      .clock  (clock),
      .reset  (reset),
      .start  (finish),
      .width  (tick_ff),
      .cfg    (calc_cfg),
      .status (calc_status)
   );

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         trigger_ticks_ff <= urtc_pkg::TRIGGER_TICKS_RESET;
         cm_scale_ff      <= urtc_pkg::CM_SCALE_RESET;
         threshold_ff     <= urtc_pkg::THRESHOLD_RESET;
         numerator_ff     <= urtc_pkg::TONE_NUMERATOR_RESET;
      end else if (csr_we) begin
         case (urtc_pkg::csr_index_type'(csr_index))
            urtc_pkg::CSR_TRIGGER_TICKS:  trigger_ticks_ff <= csr_data[urtc_pkg::TRIG_W-1:0];
            urtc_pkg::CSR_CM_SCALE:       cm_scale_ff      <= csr_data[urtc_pkg::SCALE_W-1:0];
            urtc_pkg::CSR_THRESHOLD:      threshold_ff     <= csr_data[urtc_pkg::THRESH_W-1:0];
            urtc_pkg::CSR_TONE_NUMERATOR: numerator_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // phase machine and result beat register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         tick_ff      <= '0;
         echo_prev_ff <= 1'b0;
         calc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if ((req_fire && !finish) || calc_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (req_fire) begin
            echo_prev_ff <= req_bus.echo_in;
            case (phase_ff)
               PH_IDLE: begin
                  if (req_bus.start_request) begin
                     phase_ff <= PH_TRIG;
                     tick_ff  <= '0;
                  end
               end
               PH_TRIG: begin
                  if (tick_inc >= COUNT_WIDTH'(trig_len)) begin
                     phase_ff <= PH_WAIT;
                     tick_ff  <= '0;
                  end else begin
                     tick_ff <= tick_inc;
                  end
               end
               PH_WAIT: begin
                  if (req_bus.echo_in && !echo_prev_ff) begin
                     phase_ff <= PH_MEAS;
                     tick_ff  <= COUNT_WIDTH'(1);
                  end
               end
               PH_MEAS: begin
                  if (req_bus.echo_in) begin
                     if (tick_ff != '1) begin
                        tick_ff <= tick_inc;
                     end
                  end else begin
                     calc_ff  <= 1'b1;
                     phase_ff <= PH_IDLE;
                     tick_ff  <= '0;
                  end
               end
               default: begin
                  phase_ff <= PH_IDLE;
                  tick_ff  <= '0;
               end
            endcase

            if (!finish) begin
               rsp_trigger_ff  <= (phase_ff == PH_TRIG);
               rsp_busy_ff     <= (phase_ff != PH_IDLE);
               rsp_done_ff     <= 1'b0;
               rsp_distance_ff <= calc_status.distance;
               rsp_tone_ff     <= calc_status.tone_on;
               rsp_divisor_ff  <= calc_status.divisor;
            end
         end

         // beat of the tick that closed the echo, once the arithmetic is through
         if (calc_done) begin
            calc_ff         <= 1'b0;
            rsp_trigger_ff  <= 1'b0;
            rsp_busy_ff     <= 1'b1;
            rsp_done_ff     <= 1'b1;
            rsp_distance_ff <= calc_status.distance;
            rsp_tone_ff     <= calc_status.tone_on;
            rsp_divisor_ff  <= calc_status.divisor;
         end
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.trigger_out  = rsp_trigger_ff;
   assign rsp_bus.busy_res     = rsp_busy_ff;
   assign rsp_bus.measure_done = rsp_done_ff;
   assign rsp_bus.distance_cm  = rsp_distance_ff;
   assign rsp_bus.tone_on      = rsp_tone_ff;
   assign rsp_bus.tone_divisor = rsp_divisor_ff;

endmodule

`default_nettype wire
